// ===== hdl/kev_pkg.sv =====
// ----------------------------------------------------------------------------
// kev_pkg: shared types and constants for the key event queue
// Request codes, event layout, keysym to key code mapping, and the structs
// between the sequencer, the key state memory and the event FIFO.
// ----------------------------------------------------------------------------
package kev_pkg;

    localparam int KEY_CODE_W = 10;
    localparam int KEY_VAL_W  = 2;
    localparam int KEYSYM_W   = 29;
    localparam int ROW_W      = 32;   // key state bits per memory row
    localparam int ROW_SEL_W  = 5;    // bit select inside a row

    typedef enum logic [1:0] {
        MODE_KEY   = 2'd0,
        MODE_READ  = 2'd1,
        MODE_CLEAR = 2'd2
    } t_mode;

    localparam logic [KEY_VAL_W-1:0] KV_RELEASE = 2'd0;
    localparam logic [KEY_VAL_W-1:0] KV_PRESS   = 2'd1;
    localparam logic [KEY_VAL_W-1:0] KV_REPEAT  = 2'd2;

    typedef struct packed {
        logic [KEY_CODE_W-1:0] code;
        logic [KEY_VAL_W-1:0]  value;
    } t_event;

    typedef struct packed {
        logic   push;
        logic   pop;
        logic   clear;
        t_event data;
    } t_fifo_req;

    typedef struct packed {
        logic empty;
        logic full;
    } t_fifo_stat;

    typedef struct packed {
        logic rd;
        logic wr;
    } t_map_ctl;

    localparam logic [KEY_CODE_W-1:0] LETTER_CODE [26] = '{
        10'd30, 10'd48, 10'd46, 10'd32, 10'd18, 10'd33, 10'd34, 10'd35, 10'd23,
        10'd36, 10'd37, 10'd38, 10'd50, 10'd49, 10'd24, 10'd25, 10'd16, 10'd19,
        10'd31, 10'd20, 10'd22, 10'd47, 10'd17, 10'd45, 10'd21, 10'd44
    };

    localparam logic [KEY_CODE_W-1:0] DIGIT_CODE [10] = '{
        10'd11, 10'd2, 10'd3, 10'd4, 10'd5, 10'd6, 10'd7, 10'd8, 10'd9, 10'd10
    };

    // Returns 0 for an unmapped keysym.
    function automatic logic [KEY_CODE_W-1:0] map_keysym(input logic [KEYSYM_W-1:0] sym);
        logic [KEYSYM_W-1:0]   ofs;
        logic [KEY_CODE_W-1:0] code;
        ofs  = '0;
        code = '0;
        if (sym inside {[29'h61:29'h7a]}) begin
            ofs  = sym - 29'h61;
            code = LETTER_CODE[ofs[4:0]];
        end else if (sym inside {[29'h41:29'h5a]}) begin
            ofs  = sym - 29'h41;
            code = LETTER_CODE[ofs[4:0]];
        end else if (sym inside {[29'h30:29'h39]}) begin
            ofs  = sym - 29'h30;
            code = DIGIT_CODE[ofs[3:0]];
        end else begin
            case (sym)
                29'hff1b: code = 10'd1;
                29'hff0d: code = 10'd28;
                29'h0020: code = 10'd57;
                29'hff09: code = 10'd15;
                29'hff08: code = 10'd14;
                29'hffe1: code = 10'd42;
                29'hffe2: code = 10'd54;
                29'hffe3: code = 10'd29;
                29'hffe4: code = 10'd97;
                29'hffe9: code = 10'd56;
                29'hffea: code = 10'd100;
                29'hffeb, 29'hffe7: code = 10'd125;
                29'hffec, 29'hffe8: code = 10'd126;
                29'hffe5: code = 10'd58;
                29'hff51: code = 10'd105;
                29'hff53: code = 10'd106;
                29'hff52: code = 10'd103;
                29'hff54: code = 10'd108;
                29'hff50: code = 10'd102;
                29'hff57: code = 10'd107;
                29'hff55: code = 10'd104;
                29'hff56: code = 10'd109;
                29'hff63: code = 10'd110;
                29'hffff: code = 10'd111;
                29'hffbe: code = 10'd59;
                29'hffbf: code = 10'd60;
                29'hffc0: code = 10'd61;
                29'hffc1: code = 10'd62;
                29'hffc2: code = 10'd63;
                29'hffc3: code = 10'd64;
                29'hffc4: code = 10'd65;
                29'hffc5: code = 10'd66;
                29'hffc6: code = 10'd67;
                29'hffc7: code = 10'd68;
                29'hffc8: code = 10'd87;
                29'hffc9: code = 10'd88;
                29'h0060, 29'h007e: code = 10'd41;
                29'h002d, 29'h005f: code = 10'd12;
                29'h003d, 29'h002b: code = 10'd13;
                29'h005b, 29'h007b: code = 10'd26;
                29'h005d, 29'h007d: code = 10'd27;
                29'h005c, 29'h007c: code = 10'd43;
                29'h003b, 29'h003a: code = 10'd39;
                29'h0027, 29'h0022: code = 10'd40;
                29'h002c, 29'h003c: code = 10'd51;
                29'h002e, 29'h003e: code = 10'd52;
                29'h002f, 29'h003f: code = 10'd53;
                29'hffb0: code = 10'd82;
                29'hffb1: code = 10'd79;
                29'hffb2: code = 10'd80;
                29'hffb3: code = 10'd81;
                29'hffb4: code = 10'd75;
                29'hffb5: code = 10'd76;
                29'hffb6: code = 10'd77;
                29'hffb7: code = 10'd71;
                29'hffb8: code = 10'd72;
                29'hffb9: code = 10'd73;
                29'hffab: code = 10'd78;
                29'hffad: code = 10'd74;
                29'hffaa: code = 10'd55;
                29'hffaf: code = 10'd98;
                29'hffae: code = 10'd83;
                29'hff8d: code = 10'd96;
                default:  code = '0;
            endcase
        end
        return code;
    endfunction

endpackage

// ===== hdl/kev_keymap.sv =====
// ----------------------------------------------------------------------------
// kev_keymap: key held bitmap memory
// One bit per key code, stored as rows of 32 bits in a synchronous memory
// with one write port and one registered read port.
// ----------------------------------------------------------------------------
module kev_keymap #(
    parameter int ROWS = 24
) (
    input  logic                           i_clk,
    input  kev_pkg::t_map_ctl              i_ctl,
    input  logic [$clog2(ROWS)-1:0]        i_addr,
    input  logic [kev_pkg::ROW_W-1:0]      i_wdata,
    output logic [kev_pkg::ROW_W-1:0]      o_rdata
);

    logic [kev_pkg::ROW_W-1:0] r_mem [ROWS];
    logic [kev_pkg::ROW_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_ctl.rd) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/kev_fifo.sv =====
// ----------------------------------------------------------------------------
// kev_fifo: event ring buffer
// Synchronous event memory with read and write indices and a fill count.
// A push into a full buffer is dropped; a pop of an empty buffer does nothing.
// ----------------------------------------------------------------------------
module kev_fifo #(
    parameter int DEPTH = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  kev_pkg::t_fifo_req  i_req,
    output kev_pkg::t_fifo_stat o_stat,
    output kev_pkg::t_event     o_rdata
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    kev_pkg::t_event  r_mem [DEPTH];
    kev_pkg::t_event  r_rdata;
    logic [IDX_W-1:0] r_rd_idx, n_rd_idx;
    logic [IDX_W-1:0] r_wr_idx, n_wr_idx;
    logic [CNT_W-1:0] r_count,  n_count;
    logic             empty, full, do_push, do_pop;

    assign empty   = (r_count == '0);
    assign full    = (r_count == CNT_W'(DEPTH));
    assign do_push = i_req.push && !full;
    assign do_pop  = i_req.pop && !empty;

    always_comb begin
        n_rd_idx = r_rd_idx;
        n_wr_idx = r_wr_idx;
        n_count  = r_count;
        if (i_req.clear) begin
            n_rd_idx = '0;
            n_wr_idx = '0;
            n_count  = '0;
        end else if (do_push) begin
            n_wr_idx = (r_wr_idx == IDX_W'(DEPTH - 1)) ? '0 : r_wr_idx + 1'b1;
            n_count  = r_count + 1'b1;
        end else if (do_pop) begin
            n_rd_idx = (r_rd_idx == IDX_W'(DEPTH - 1)) ? '0 : r_rd_idx + 1'b1;
            n_count  = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx <= '0;
            r_wr_idx <= '0;
            r_count  <= '0;
        end else begin
            r_rd_idx <= n_rd_idx;
            r_wr_idx <= n_wr_idx;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push && !i_req.clear) begin
            r_mem[r_wr_idx] <= i_req.data;
        end
        if (do_pop && !i_req.clear) begin
            r_rdata <= r_mem[r_rd_idx];
        end
    end

    assign o_stat.empty = empty;
    assign o_stat.full  = full;
    assign o_rdata      = r_rdata;

endmodule

// ===== hdl/key_event_queue.sv =====
// ----------------------------------------------------------------------------
// key_event_queue: keyboard event controller with event FIFO
// Maps keysyms to key codes, tracks held keys in a bitmap memory and queues
// press, repeat and release events for readout.
// ----------------------------------------------------------------------------
//  channel | valid    | stall    | payload
//  --------+----------+----------+------------------------------------------
//  request | i_valid  | o_stall  | i_mode, i_keysym, i_pressed
//  result  | o_valid  | i_stall  | o_has_event, o_key_code, o_key_value
//
//  Key request: read-modify-write of one bitmap row, written back in ST_KEY.
//  Read request: FIFO memory read, held in ST_READ while the result register
//  is still full; unmapped keys and unused modes leave the block in ST_IDLE.
//  Reset and clear requests sweep the bitmap one row per cycle, with o_stall
//  high, over ceil(KEY_COUNT/32) rows (24 at the default).
//  A waiting result does not block key or clear requests.
// ----------------------------------------------------------------------------
module key_event_queue #(
    parameter int QUEUE_DEPTH = 256,
    parameter int KEY_COUNT   = 768
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [1:0]                         i_mode,
    input  logic [kev_pkg::KEYSYM_W-1:0]       i_keysym,
    input  logic                               i_pressed,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic                               o_has_event,
    output logic [kev_pkg::KEY_CODE_W-1:0]     o_key_code,
    output logic [kev_pkg::KEY_VAL_W-1:0]      o_key_value
);

    localparam int KEY_ROWS = (KEY_COUNT + kev_pkg::ROW_W - 1) / kev_pkg::ROW_W;
    localparam int ROW_AW   = $clog2(KEY_ROWS);

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_KEY   = 4'b0100,
        ST_READ  = 4'b1000
    } t_state;

    t_state                            r_state, n_state;
    logic [ROW_AW-1:0]                 r_sweep, n_sweep;
    logic [kev_pkg::KEY_CODE_W-1:0]    r_code;
    logic                              r_pressed;
    logic                              r_empty;
    logic                              r_out_valid, n_out_valid;
    logic                              r_has_event;
    logic [kev_pkg::KEY_CODE_W-1:0]    r_out_code;
    logic [kev_pkg::KEY_VAL_W-1:0]     r_out_value;

    logic                              accept, key_ok, held, enq, out_load;
    logic [kev_pkg::KEY_CODE_W-1:0]    mapped;
    logic [kev_pkg::KEY_VAL_W-1:0]     value;
    logic [kev_pkg::ROW_W-1:0]         row_rdata, row_wdata;
    logic [ROW_AW-1:0]                 row_addr;
    kev_pkg::t_map_ctl                 map_ctl;
    kev_pkg::t_fifo_req                fifo_req;
    kev_pkg::t_fifo_stat               fifo_stat;
    kev_pkg::t_event                   fifo_rdata;

    assign o_stall = (r_state != ST_IDLE);
    assign accept  = i_valid && !o_stall;
    assign mapped  = kev_pkg::map_keysym(i_keysym);
    assign key_ok  = (mapped != '0) && ({1'b0, mapped} < 11'(KEY_COUNT));

    // bitmap update for the pending key request
    assign held = row_rdata[r_code[kev_pkg::ROW_SEL_W-1:0]];

    always_comb begin
        row_wdata = row_rdata;
        enq       = 1'b0;
        value     = kev_pkg::KV_RELEASE;
        if (r_pressed) begin
            enq   = 1'b1;
            value = held ? kev_pkg::KV_REPEAT : kev_pkg::KV_PRESS;
            row_wdata[r_code[kev_pkg::ROW_SEL_W-1:0]] = 1'b1;
        end else if (held) begin
            enq   = 1'b1;
            row_wdata[r_code[kev_pkg::ROW_SEL_W-1:0]] = 1'b0;
        end
    end

    always_comb begin
        if (r_state == ST_CLEAR) begin
            row_addr = r_sweep;
        end else if (r_state == ST_KEY) begin
            row_addr = r_code[ROW_AW+kev_pkg::ROW_SEL_W-1:kev_pkg::ROW_SEL_W];
        end else begin
            row_addr = mapped[ROW_AW+kev_pkg::ROW_SEL_W-1:kev_pkg::ROW_SEL_W];
        end
    end

    assign map_ctl.rd = accept && (i_mode == kev_pkg::MODE_KEY) && key_ok;
    assign map_ctl.wr = (r_state == ST_CLEAR) || (r_state == ST_KEY);

    assign fifo_req.push       = (r_state == ST_KEY) && enq;
    assign fifo_req.pop        = accept && (i_mode == kev_pkg::MODE_READ);
    assign fifo_req.clear      = accept && (i_mode == kev_pkg::MODE_CLEAR);
    assign fifo_req.data.code  = r_code;
    assign fifo_req.data.value = value;

    assign out_load = (r_state == ST_READ) && (!r_out_valid || !i_stall);

    always_comb begin
        n_state = r_state;
        n_sweep = r_sweep;
        case (r_state)
            ST_CLEAR: begin
                if (r_sweep == ROW_AW'(KEY_ROWS - 1)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_sweep = r_sweep + 1'b1;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    case (i_mode)
                        kev_pkg::MODE_KEY:   n_state = key_ok ? ST_KEY : ST_IDLE;
                        kev_pkg::MODE_READ:  n_state = ST_READ;
                        kev_pkg::MODE_CLEAR: begin
                            n_state = ST_CLEAR;
                            n_sweep = '0;
                        end
                        default:             n_state = ST_IDLE;
                    endcase
                end
            end
            ST_KEY:  n_state = ST_IDLE;
            ST_READ: n_state = out_load ? ST_IDLE : ST_READ;
            default: n_state = ST_IDLE;
        endcase
    end

    assign n_out_valid = out_load || (r_out_valid && i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_sweep     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sweep     <= n_sweep;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_code    <= mapped;
            r_pressed <= i_pressed;
            r_empty   <= fifo_stat.empty;
        end
        if (out_load) begin
            r_has_event <= !r_empty;
            r_out_code  <= r_empty ? '0 : fifo_rdata.code;
            r_out_value <= r_empty ? kev_pkg::KV_RELEASE : fifo_rdata.value;
        end
    end

    kev_keymap #(
        .ROWS (KEY_ROWS)
    ) u_keymap (
        .i_clk   (i_clk),
        .i_ctl   (map_ctl),
        .i_addr  (row_addr),
        .i_wdata (r_state == ST_CLEAR ? '0 : row_wdata),
        .o_rdata (row_rdata)
    );

    kev_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (fifo_req),
        .o_stat  (fifo_stat),
        .o_rdata (fifo_rdata)
    );

    assign o_valid     = r_out_valid;
    assign o_has_event = r_has_event;
    assign o_key_code  = r_out_code;
    assign o_key_value = r_out_value;

endmodule

// ===== hdl/kev_checker.sv =====
// ----------------------------------------------------------------------------
// kev_checker: port-level checks for key_event_queue
// Watches the request and result channels of the top level.
// ----------------------------------------------------------------------------
module kev_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_valid,
    input logic                           o_stall,
    input logic [1:0]                     i_mode,
    input logic [kev_pkg::KEYSYM_W-1:0]   i_keysym,
    input logic                           i_pressed,
    input logic                           o_valid,
    input logic                           i_stall,
    input logic                           o_has_event,
    input logic [kev_pkg::KEY_CODE_W-1:0] o_key_code,
    input logic [kev_pkg::KEY_VAL_W-1:0]  o_key_value
);

    // bitmap sweep holds off requests right after reset
    a_reset_sweep: assert property (@(posedge i_clk)
        !i_rst_n |=> o_stall)
        else $error("requests not held off after reset");

    // an accepted read request raises o_stall
    a_read_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_mode == kev_pkg::MODE_READ) |=> o_stall)
        else $error("read request did not hold off the next request");

    // an empty read carries code and value zero
    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_has_event) |-> (o_key_code == '0 && o_key_value == '0))
        else $error("empty read with nonzero payload");

    a_value_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_key_value != 2'd3))
        else $error("key value out of range");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_has_event)
                                  && $stable(o_key_code) && $stable(o_key_value)))
        else $error("stalled result changed");

endmodule

bind key_event_queue kev_checker u_kev_checker (.*);

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for key_event_queue
// Drives key, read, clear and unused requests through the request channel.
// A predictor keeps its own key bitmap and event queue, and each read result
// is checked field by field in arrival order. Both channels idle in random
// bursts. The receiver also holds off for a long stretch while reads keep
// coming, so the block backs up and stalls its input.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int KEY_COUNT      = 768;
    localparam int QUEUE_DEPTH    = 256;
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int POOL_SIZE      = 12;
    localparam int TAIL_ITEMS     = 80;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int REPORT_LIMIT   = 10;

    typedef struct {
        logic [1:0]                   mode;
        logic [kev_pkg::KEYSYM_W-1:0] keysym;
        logic                         pressed;
        bit                           hold;
    } t_kbd_request;

    typedef struct {
        logic                           has_event;
        logic [kev_pkg::KEY_CODE_W-1:0] code;
        logic [kev_pkg::KEY_VAL_W-1:0]  value;
    } t_read_result;

    // keysym to key code tables: letters a..z, digits 0..9, then {sym, code}
    localparam logic [kev_pkg::KEY_CODE_W-1:0] LETTER_KEYS [26] = '{
        30, 48, 46, 32, 18, 33, 34, 35, 23, 36, 37, 38, 50,
        49, 24, 25, 16, 19, 31, 20, 22, 47, 17, 45, 21, 44
    };
    localparam logic [kev_pkg::KEY_CODE_W-1:0] DIGIT_KEYS [10] = '{
        11, 2, 3, 4, 5, 6, 7, 8, 9, 10
    };
    localparam int NAMED_COUNT = 76;
    localparam logic [25:0] NAMED_KEYS [NAMED_COUNT] = '{
        {16'hff1b, 10'd1},   {16'hff0d, 10'd28},  {16'h0020, 10'd57},
        {16'hff09, 10'd15},  {16'hff08, 10'd14},  {16'hffe1, 10'd42},
        {16'hffe2, 10'd54},  {16'hffe3, 10'd29},  {16'hffe4, 10'd97},
        {16'hffe9, 10'd56},  {16'hffea, 10'd100}, {16'hffeb, 10'd125},
        {16'hffe7, 10'd125}, {16'hffec, 10'd126}, {16'hffe8, 10'd126},
        {16'hffe5, 10'd58},  {16'hff51, 10'd105}, {16'hff53, 10'd106},
        {16'hff52, 10'd103}, {16'hff54, 10'd108}, {16'hff50, 10'd102},
        {16'hff57, 10'd107}, {16'hff55, 10'd104}, {16'hff56, 10'd109},
        {16'hff63, 10'd110}, {16'hffff, 10'd111}, {16'hffbe, 10'd59},
        {16'hffbf, 10'd60},  {16'hffc0, 10'd61},  {16'hffc1, 10'd62},
        {16'hffc2, 10'd63},  {16'hffc3, 10'd64},  {16'hffc4, 10'd65},
        {16'hffc5, 10'd66},  {16'hffc6, 10'd67},  {16'hffc7, 10'd68},
        {16'hffc8, 10'd87},  {16'hffc9, 10'd88},  {16'h0060, 10'd41},
        {16'h007e, 10'd41},  {16'h002d, 10'd12},  {16'h005f, 10'd12},
        {16'h003d, 10'd13},  {16'h002b, 10'd13},  {16'h005b, 10'd26},
        {16'h007b, 10'd26},  {16'h005d, 10'd27},  {16'h007d, 10'd27},
        {16'h005c, 10'd43},  {16'h007c, 10'd43},  {16'h003b, 10'd39},
        {16'h003a, 10'd39},  {16'h0027, 10'd40},  {16'h0022, 10'd40},
        {16'h002c, 10'd51},  {16'h003c, 10'd51},  {16'h002e, 10'd52},
        {16'h003e, 10'd52},  {16'h002f, 10'd53},  {16'h003f, 10'd53},
        {16'hffb0, 10'd82},  {16'hffb1, 10'd79},  {16'hffb2, 10'd80},
        {16'hffb3, 10'd81},  {16'hffb4, 10'd75},  {16'hffb5, 10'd76},
        {16'hffb6, 10'd77},  {16'hffb7, 10'd71},  {16'hffb8, 10'd72},
        {16'hffb9, 10'd73},  {16'hffab, 10'd78},  {16'hffad, 10'd74},
        {16'hffaa, 10'd55},  {16'hffaf, 10'd98},  {16'hffae, 10'd83},
        {16'hff8d, 10'd96}
    };

    logic                           i_clk     = 1'b0;
    logic                           i_rst_n   = 1'b0;
    logic                           i_valid   = 1'b0;
    logic                           o_stall;
    logic [1:0]                     i_mode    = '0;
    logic [kev_pkg::KEYSYM_W-1:0]   i_keysym  = '0;
    logic                           i_pressed = 1'b0;
    logic                           o_valid;
    logic                           i_stall   = 1'b0;
    logic                           o_has_event;
    logic [kev_pkg::KEY_CODE_W-1:0] o_key_code;
    logic [kev_pkg::KEY_VAL_W-1:0]  o_key_value;

    t_kbd_request                 pending [$];
    t_kbd_request                 in_flight;
    t_read_result                 reads_due [$];
    kev_pkg::t_event              queued_events [$];
    bit                           held_keys [KEY_COUNT];
    logic [kev_pkg::KEYSYM_W-1:0] key_pool [POOL_SIZE];

    int n_total;
    int n_accepted;
    int n_errors;
    int send_gap;
    int stall_left;
    int hold_left;
    int hold_asks;
    int hold_taken;
    int idle_cycles;
    bit quiet_tail;

    key_event_queue #(
        .QUEUE_DEPTH(QUEUE_DEPTH),
        .KEY_COUNT  (KEY_COUNT)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_mode     (i_mode),
        .i_keysym   (i_keysym),
        .i_pressed  (i_pressed),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_has_event(o_has_event),
        .o_key_code (o_key_code),
        .o_key_value(o_key_value)
    );

    always #5 i_clk = ~i_clk;

    // 0 means unmapped
    function automatic logic [kev_pkg::KEY_CODE_W-1:0] code_of(
        input logic [kev_pkg::KEYSYM_W-1:0] sym
    );
        logic [kev_pkg::KEY_CODE_W-1:0] code;
        logic [kev_pkg::KEYSYM_W-1:0]   ofs;
        code = '0;
        ofs  = '0;
        if (sym >= 29'h61 && sym <= 29'h7a) begin
            ofs  = sym - 29'h61;
            code = LETTER_KEYS[ofs[4:0]];
        end else if (sym >= 29'h41 && sym <= 29'h5a) begin
            ofs  = sym - 29'h41;
            code = LETTER_KEYS[ofs[4:0]];
        end else if (sym >= 29'h30 && sym <= 29'h39) begin
            ofs  = sym - 29'h30;
            code = DIGIT_KEYS[ofs[3:0]];
        end else if (sym[kev_pkg::KEYSYM_W-1:16] == '0) begin
            foreach (NAMED_KEYS[i])
                if (NAMED_KEYS[i][25:10] == sym[15:0]) code = NAMED_KEYS[i][9:0];
        end
        return code;
    endfunction

    function automatic void update_key_state(input t_kbd_request r);
        logic [kev_pkg::KEY_CODE_W-1:0] code;
        kev_pkg::t_event                ev;
        bit                             emit;
        emit = 1'b0;
        case (r.mode)
            kev_pkg::MODE_KEY: begin
                code = code_of(r.keysym);
                ev.code = code;
                if (code != '0 && code < KEY_COUNT) begin
                    if (r.pressed) begin
                        ev.value = held_keys[code] ? kev_pkg::KV_REPEAT : kev_pkg::KV_PRESS;
                        held_keys[code] = 1'b1;
                        emit = 1'b1;
                    end else if (held_keys[code]) begin
                        ev.value = kev_pkg::KV_RELEASE;
                        held_keys[code] = 1'b0;
                        emit = 1'b1;
                    end
                end
                // bitmap still updates when the queue is full; the event is dropped
                if (emit && queued_events.size() < QUEUE_DEPTH) queued_events.push_back(ev);
            end
            kev_pkg::MODE_READ: begin
                if (queued_events.size() == 0) begin
                    reads_due.push_back('{1'b0, '0, '0});
                end else begin
                    ev = queued_events.pop_front();
                    reads_due.push_back('{1'b1, ev.code, ev.value});
                end
            end
            kev_pkg::MODE_CLEAR: begin
                foreach (held_keys[i]) held_keys[i] = 1'b0;
                queued_events.delete();
            end
            default: ;
        endcase
    endfunction

    function automatic logic [kev_pkg::KEYSYM_W-1:0] any_mapped_sym();
        case ($urandom_range(0, 3))
            0:       return 29'h61 + 29'($urandom_range(0, 25));
            1:       return 29'h41 + 29'($urandom_range(0, 25));
            2:       return 29'h30 + 29'($urandom_range(0, 9));
            default: return {13'd0, NAMED_KEYS[7'($urandom_range(0, NAMED_COUNT - 1))][25:10]};
        endcase
    endfunction

    function automatic void push_req(input logic [1:0] mode,
                                     input logic [kev_pkg::KEYSYM_W-1:0] sym,
                                     input logic pressed, input bit hold);
        t_kbd_request r;
        r.mode    = mode;
        r.keysym  = sym;
        r.pressed = pressed;
        r.hold    = hold;
        pending.push_back(r);
    endfunction

    function automatic void refill_pool();
        foreach (key_pool[i]) key_pool[i] = any_mapped_sym();
    endfunction

    // key press/repeat/release sequences on a few keys, plus reads, clears and noise
    function automatic void add_mix(input int n);
        int pick;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                push_req(kev_pkg::MODE_KEY, key_pool[4'($urandom_range(0, POOL_SIZE - 1))],
                         1'($urandom), 1'b0);
            else if (pick < 55)
                push_req(kev_pkg::MODE_KEY, any_mapped_sym(), 1'($urandom), 1'b0);
            else if (pick < 61)
                push_req(kev_pkg::MODE_KEY, 29'($urandom), 1'($urandom), 1'b0);
            else if (pick < 63)
                push_req(MODE_UNUSED, 29'($urandom), 1'($urandom), 1'b0);
            else if (pick < 65)
                push_req(kev_pkg::MODE_CLEAR, 29'($urandom), 1'($urandom), 1'b0);
            else
                push_req(kev_pkg::MODE_READ, 29'($urandom), 1'($urandom), 1'b0);
        end
    endfunction

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                update_key_state(in_flight);
                n_accepted++;
            end
            if (!i_valid || !o_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
                    send_gap = $urandom_range(0, 17);
                    i_valid <= 1'b0;
                end else if (pending.size() > 0) begin
                    in_flight = pending.pop_front();
                    if (in_flight.hold) hold_asks++;
                    quiet_tail = (pending.size() < TAIL_ITEMS);
                    i_valid   <= 1'b1;
                    i_mode    <= in_flight.mode;
                    i_keysym  <= in_flight.keysym;
                    i_pressed <= in_flight.pressed;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stall
    always @(posedge i_clk) begin
        t_read_result want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (reads_due.size() == 0) begin
                    n_errors++;
                    if (n_errors <= REPORT_LIMIT)
                        $display("%0t: unexpected result has=%0b code=%0d value=%0d",
                                 $realtime, o_has_event, o_key_code, o_key_value);
                end else begin
                    want = reads_due.pop_front();
                    if (o_has_event !== want.has_event || o_key_code !== want.code ||
                        o_key_value !== want.value) begin
                        n_errors++;
                        if (n_errors <= REPORT_LIMIT)
                            $display({"%0t: read mismatch exp has=%0b code=%0d value=%0d,",
                                      " got has=%0b code=%0d value=%0d"},
                                     $realtime, want.has_event, want.code, want.value,
                                     o_has_event, o_key_code, o_key_value);
                    end
                end
            end
            if (hold_taken != hold_asks) begin
                hold_taken = hold_asks;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(0, 17);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // cycles with no request and no result accepted
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        // directed: empty read, unmapped extremes, release of an idle key,
        // press / autorepeat / release, alias ranges, mode 3, clear
        push_req(kev_pkg::MODE_READ, '1, 1'b1, 1'b0);
        push_req(kev_pkg::MODE_KEY, 29'h0, 1'b1, 1'b0);
        push_req(kev_pkg::MODE_KEY, 29'h1fff_ffff, 1'b1, 1'b0);
        push_req(kev_pkg::MODE_KEY, 29'h61, 1'b0, 1'b0);
        push_req(kev_pkg::MODE_KEY, 29'h61, 1'b1, 1'b0);
        push_req(kev_pkg::MODE_KEY, 29'h61, 1'b1, 1'b0);
        push_req(kev_pkg::MODE_KEY, 29'h61, 1'b0, 1'b0);
        push_req(kev_pkg::MODE_KEY, 29'h5a, 1'b1, 1'b0);
        push_req(kev_pkg::MODE_KEY, 29'h30, 1'b1, 1'b0);
        push_req(kev_pkg::MODE_KEY, 29'hffff, 1'b1, 1'b0);
        push_req(kev_pkg::MODE_KEY, 29'h1000_ff1b, 1'b1, 1'b0);   // high bits set: not Escape
        push_req(MODE_UNUSED, '1, 1'b1, 1'b0);
        repeat (7) push_req(kev_pkg::MODE_READ, '0, 1'b0, 1'b0);
        push_req(kev_pkg::MODE_KEY, 29'h61, 1'b1, 1'b0);
        push_req(kev_pkg::MODE_CLEAR, '0, 1'b0, 1'b0);
        push_req(kev_pkg::MODE_KEY, 29'h61, 1'b0, 1'b0);          // no longer held after clear
        push_req(kev_pkg::MODE_READ, '0, 1'b0, 1'b0);

        refill_pool();
        add_mix(30);

        // overfill the queue, then drain it while the receiver holds off at first
        push_req(kev_pkg::MODE_CLEAR, 29'($urandom), 1'($urandom), 1'b0);
        refill_pool();
        repeat (300)
            push_req(kev_pkg::MODE_KEY, key_pool[4'($urandom_range(0, POOL_SIZE - 1))],
                     $urandom_range(0, 99) < 90, 1'b0);
        push_req(kev_pkg::MODE_READ, 29'($urandom), 1'($urandom), 1'b1);
        repeat (264) push_req(kev_pkg::MODE_READ, 29'($urandom), 1'($urandom), 1'b0);

        refill_pool();
        add_mix(TAIL_ITEMS);
        n_total = pending.size();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_accepted < n_total || reads_due.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (n_errors == 0 && reads_due.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
